[src/rsae_pkg.sv]
// shared types, constants and functions for the gf32 address encoder
package rsae_pkg;

    localparam int ID_W        = 64;
    localparam int SYM_W       = 5;
    localparam int DATA_SYMS   = 13;
    localparam int CODE_SYMS   = 17;
    localparam int ADDR_CHARS  = 20;
    localparam int CHAR_W      = 7;
    localparam int POS_W       = $clog2(ADDR_CHARS);
    localparam int STAGES      = 4;
    localparam int STEPS_PER   = 4;

    localparam logic [SYM_W-1:0] GEN_C0 = 5'd17;
    localparam logic [SYM_W-1:0] GEN_C1 = 5'd9;
    localparam logic [SYM_W-1:0] GEN_C2 = 5'd6;
    localparam logic [SYM_W-1:0] GEN_C3 = 5'd30;
    localparam logic [SYM_W:0]   FIELD_POLY = 6'h25;

    localparam logic [CHAR_W-1:0] DASH_CHAR = 7'd45;
    localparam logic [0:31][7:0]  ALPHABET  = "23456789ABCDEFGHJKLMNPQRSTUVWXYZ";

    typedef logic [SYM_W-1:0] t_sym;
    typedef t_sym [CODE_SYMS-1:0] t_codeword;

    // parity register file of the lfsr
    typedef struct packed {
        t_sym r3;
        t_sym r2;
        t_sym r1;
        t_sym r0;
    } t_par;

    // one output slot: either a dash or a codeword symbol index
    typedef struct packed {
        logic       dash;
        t_sym       idx;
    } t_slot;

    // gf(32) multiply, reduction polynomial x^5+x^2+1
    function automatic t_sym gf_mul(input t_sym a, input t_sym b);
        logic [SYM_W:0] x;
        t_sym           acc;
        x   = {1'b0, a};
        acc = '0;
        for (int k = 0; k < SYM_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x[SYM_W-1:0];
            end
            x = {x[SYM_W-1:0], 1'b0};
            if (x[SYM_W]) begin
                x = x ^ FIELD_POLY;
            end
        end
        return acc;
    endfunction

    // base-32 digit at a fixed position, the top digit holds four bits
    function automatic t_sym digit_at(input logic [ID_W-1:0] id, input int idx);
        logic [ID_W-1:0] sh;
        sh = id >> (SYM_W * idx);
        return sh[SYM_W-1:0];
    endfunction

    // one lfsr step with data symbol d
    function automatic t_par lfsr_step(input t_par p, input t_sym d);
        t_par q;
        t_sym fb;
        fb   = d ^ p.r3;
        q.r3 = p.r2 ^ gf_mul(GEN_C3, fb);
        q.r2 = p.r1 ^ gf_mul(GEN_C2, fb);
        q.r1 = p.r0 ^ gf_mul(GEN_C1, fb);
        q.r0 = gf_mul(GEN_C0, fb);
        return q;
    endfunction

    // character position to codeword symbol or dash
    function automatic t_slot slot_at(input logic [POS_W-1:0] pos);
        t_slot s;
        s = '{dash: 1'b0, idx: 5'd0};
        case (pos)
            5'd0:    s.idx = 5'd3;
            5'd1:    s.idx = 5'd2;
            5'd2:    s.idx = 5'd1;
            5'd3:    s.idx = 5'd0;
            5'd4:    s.dash = 1'b1;
            5'd5:    s.idx = 5'd7;
            5'd6:    s.idx = 5'd6;
            5'd7:    s.idx = 5'd5;
            5'd8:    s.idx = 5'd4;
            5'd9:    s.dash = 1'b1;
            5'd10:   s.idx = 5'd13;
            5'd11:   s.idx = 5'd14;
            5'd12:   s.idx = 5'd15;
            5'd13:   s.idx = 5'd16;
            5'd14:   s.dash = 1'b1;
            5'd15:   s.idx = 5'd12;
            5'd16:   s.idx = 5'd8;
            5'd17:   s.idx = 5'd9;
            5'd18:   s.idx = 5'd10;
            5'd19:   s.idx = 5'd11;
            default: s.dash = 1'b1;
        endcase
        return s;
    endfunction

    // symbol to ascii character
    function automatic logic [CHAR_W-1:0] sym_char(input t_sym s);
        logic [7:0] c;
        c = ALPHABET[s];
        return c[CHAR_W-1:0];
    endfunction

endpackage

[src/rsae_parity.sv]
// pipelined reed-solomon parity lfsr, four register stages
module rsae_parity (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [rsae_pkg::ID_W-1:0]   i_id,
    output logic                        o_ready,
    output logic                        o_valid,
    output rsae_pkg::t_codeword         o_cw,
    input  logic                        i_ready
);
    import rsae_pkg::*;

    logic [STAGES-1:0]   r_valid;
    logic [ID_W-1:0]     r_id  [STAGES];
    t_par                r_par [STAGES];
    t_par                n_par [STAGES];
    logic [STAGES-1:0]   adv;

    // stage advance, a stage moves when it is empty or its successor moves
    always_comb begin
        adv[STAGES-1] = !r_valid[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_valid[k] || adv[k+1];
        end
    end

    // lfsr steps per stage, digits fed from most significant down
    always_comb begin
        t_par            p;
        logic [ID_W-1:0] id;
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                p  = '0;
                id = i_id;
            end else begin
                p  = r_par[k-1];
                id = r_id[k-1];
            end
            for (int j = 0; j < STEPS_PER; j++) begin
                if (DATA_SYMS - 1 - STEPS_PER * k - j >= 0) begin
                    p = lfsr_step(p, digit_at(id, DATA_SYMS - 1 - STEPS_PER * k - j));
                end
            end
            n_par[k] = p;
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (adv[k]) begin
                r_par[k] <= n_par[k];
                r_id[k]  <= (k == 0) ? i_id : r_id[k-1];
            end
        end
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (adv[k]) begin
                    r_valid[k] <= (k == 0) ? i_valid : r_valid[k-1];
                end
            end
        end
    end

    // codeword assembly: data digits then parity
    always_comb begin
        for (int i = 0; i < DATA_SYMS; i++) begin
            o_cw[i] = digit_at(r_id[STAGES-1], i);
        end
        o_cw[DATA_SYMS]     = r_par[STAGES-1].r0;
        o_cw[DATA_SYMS + 1] = r_par[STAGES-1].r1;
        o_cw[DATA_SYMS + 2] = r_par[STAGES-1].r2;
        o_cw[DATA_SYMS + 3] = r_par[STAGES-1].r3;
    end

    assign o_ready = adv[0];
    assign o_valid = r_valid[STAGES-1];

endmodule

[src/rsae_serial.sv]
// character serializer: one codeword out as twenty characters
module rsae_serial (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  rsae_pkg::t_codeword              i_cw,
    output logic                             o_ready,
    output logic                             o_valid,
    output logic [rsae_pkg::CHAR_W-1:0]      o_out_char,
    output logic                             o_last_char,
    input  logic                             i_stall
);
    import rsae_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(ADDR_CHARS - 1);

    t_codeword          r_cw;
    logic               r_busy;
    logic [POS_W-1:0]   r_pos;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;

    logic               out_load;
    logic               emit;
    logic               done;
    logic               take;
    t_slot              slot;
    logic [CHAR_W-1:0]  n_char;

    // handshake control
    always_comb begin
        out_load = !r_out_valid || !i_stall;
        emit     = r_busy && out_load;
        done     = emit && (r_pos == LAST_POS);
        o_ready  = !r_busy || done;
        take     = i_valid && o_ready;
    end

    // character lookup for the current position
    always_comb begin
        slot   = slot_at(r_pos);
        n_char = slot.dash ? DASH_CHAR : sym_char(r_cw[slot.idx]);
    end

    // codeword hold and position counter
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cw <= i_cw;
        end
        if (out_load) begin
            r_out_char <= n_char;
            r_out_last <= (r_pos == LAST_POS);
        end
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
                r_pos  <= '0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_pos <= r_pos + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= r_busy;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

endmodule

[src/rs_gf32_address_encoder_top.sv]
// path: a transaction passes the parity stages, the serializer codeword hold, then the output register
// throughput: one character per cycle while not stalled, twenty per account number,
//   set by the character serializer; the parity pipeline takes one per cycle unless held
// reset: synchronous active-low reset clears all valid bits and the serializer
//   state, no clearing pass is needed
// top level of the gf32 reed-solomon address encoder
module rs_gf32_address_encoder_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [rsae_pkg::ID_W-1:0]        i_account_id,
    output logic                             o_stall,
    output logic                             o_valid,
    output logic [rsae_pkg::CHAR_W-1:0]      o_out_char,
    output logic                             o_last_char,
    input  logic                             i_stall
);
    import rsae_pkg::*;

    logic       par_ready;
    logic       cw_valid;
    t_codeword  cw;
    logic       ser_ready;

    // parity pipeline
    rsae_parity u_parity (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_id    (i_account_id),
        .o_ready (par_ready),
        .o_valid (cw_valid),
        .o_cw    (cw),
        .i_ready (ser_ready)
    );

    // character output
    rsae_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (cw_valid),
        .i_cw        (cw),
        .o_ready     (ser_ready),
        .o_valid     (o_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char),
        .i_stall     (i_stall)
    );

    assign o_stall = !par_ready;

endmodule
